### design/pps_pkg.sv
// Shared types and constants for the operator-precedence token stack.
// Used by the channel interfaces, the stack cell, the run scan and the top level.
package pps_pkg;

	localparam int PPS_DEPTH        = 64;
	localparam int PPS_PAYLOAD_BITS = 32;
	localparam int PPS_TYPE_W       = 6;
	localparam int PPS_OUT_PAY_W    = 32;
	localparam int PPS_CFG_IDX_W    = 2;
	localparam int PPS_CNT_W        = $clog2(PPS_DEPTH + 1);

	typedef logic [PPS_TYPE_W-1:0] tok_type_t;

	typedef enum logic [1:0] {
		FN_PUSH   = 2'd0,
		FN_POP    = 2'd1,
		FN_TOP    = 2'd2,
		FN_INSERT = 2'd3
	} pps_func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_NOTERM = 2'd3
	} pps_status_t;

	typedef enum logic [PPS_CFG_IDX_W-1:0] {
		REG_MARKER = 2'd0,
		REG_END    = 2'd1,
		REG_EXPR   = 2'd2,
		REG_IDENT  = 2'd3
	} pps_reg_t;

	// per-cell next-cycle action
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_PUSH  = 2'd1,
		CELL_SHIFT = 2'd2,
		CELL_MARK  = 2'd3
	} cell_op_t;

	// token codes used by the cells and the operation decode
	typedef struct packed {
		tok_type_t marker;
		tok_type_t end_tok;
		tok_type_t expr;
		tok_type_t ident;
	} pps_cfg_t;

endpackage

### design/pps_if.sv
// Valid/ready channel interfaces for the token stack: operation in, result out.
// Depends on pps_pkg for field widths.
interface pps_in_if
	import pps_pkg::*;
();
	logic      valid;
	logic      ready;
	logic [1:0] func;
	tok_type_t token_type;
	logic [PPS_OUT_PAY_W-1:0] token_payload;

	modport source (output valid, func, token_type, token_payload, input ready);
	modport sink   (input valid, func, token_type, token_payload, output ready);
endinterface

interface pps_out_if
	import pps_pkg::*;
#(
	parameter int CNT_W = PPS_CNT_W
) ();
	logic      valid;
	logic      ready;
	logic      top_valid;
	tok_type_t top_type;
	logic [PPS_OUT_PAY_W-1:0] top_payload;
	logic [CNT_W-1:0] entry_count;
	logic [1:0] status;

	modport source (output valid, top_valid, top_type, top_payload, entry_count, status,
		input ready);
	modport sink   (input valid, top_valid, top_type, top_payload, entry_count, status,
		output ready);
endinterface

### design/pps_scan.sv
// Suffix-AND scan over the cell row: run[j] = AND of flag[j..DEPTH-1].
// Log-depth doubling network; depends on pps_pkg only for the default depth.
module pps_scan
	import pps_pkg::*;
#(
	parameter int DEPTH = PPS_DEPTH
) (
	input  logic [DEPTH-1:0] flag,
	output logic [DEPTH-1:0] run
);

	always_comb begin
		logic [DEPTH-1:0] v;
		v = flag;
		for (int s = 1; s < DEPTH; s = s * 2) begin
			for (int i = 0; i < DEPTH - s; i++) begin
				v[i] = v[i] & v[i+s];
			end
		end
		run = v;
	end

endmodule

### design/pps_cell.sv
// One stack entry: token type and payload, loaded from push data, the cell below,
// or the marker code. Depends on pps_pkg for cell_op_t and pps_cfg_t.
module pps_cell
	import pps_pkg::*;
#(
	parameter int PAYLOAD_BITS = PPS_PAYLOAD_BITS
) (
	input  logic                    clk,
	input  cell_op_t                op,
	input  pps_cfg_t                cfg,
	input  tok_type_t               push_type,
	input  logic [PAYLOAD_BITS-1:0] push_pay,
	input  tok_type_t               below_type,
	input  logic [PAYLOAD_BITS-1:0] below_pay,
	output tok_type_t               type_q,
	output logic [PAYLOAD_BITS-1:0] pay_q,
	output logic                    ei      // holds an expression or identifier
);

	always_ff @(posedge clk) begin
		case (op)
			CELL_PUSH: begin
				type_q <= push_type;
				pay_q  <= push_pay;
			end
			CELL_SHIFT: begin
				type_q <= below_type;
				pay_q  <= below_pay;
			end
			CELL_MARK: begin
				type_q <= cfg.marker;
				pay_q  <= '0;
			end
			default: ;
		endcase
	end

	assign ei = (type_q == cfg.expr) || (type_q == cfg.ident);

endmodule

### design/precedence_parser_token_stack_top.sv
// Top level of the operator-precedence token stack: config registers, cell row,
// operation decode and result register. Depends on pps_pkg, pps_if, pps_scan, pps_cell.
//
//  channel  | dir | handshake       | beat
//  ---------+-----+-----------------+-------------------------------------------------
//  in_ch    | in  | valid/ready     | func, token_type, token_payload
//  out_ch   | out | valid/ready     | top_valid, top_type, top_payload, entry_count, status
//  cfg      | in  | cfg_we (no wait)| cfg_idx, cfg_data
//
// The accept cycle of an operation beat updates the cell row; once the result register is free,
// the new top is read through the row's read mux into the result register.
// The marker search is combinational: per-cell compares plus a log-depth scan over the row.
// Reset clears the fill count and the handshake flags and loads the config registers with
// defaults; cell contents are not reset and are only read below the fill count.
// While a result beat stalls, in_ch takes at most one more operation and then holds off.
module precedence_parser_token_stack_top
	import pps_pkg::*;
#(
	parameter int DEPTH        = PPS_DEPTH,
	parameter int PAYLOAD_BITS = PPS_PAYLOAD_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	pps_in_if.sink                    in_ch,
	pps_out_if.source                 out_ch,
	input  logic                      cfg_we,
	input  logic [PPS_CFG_IDX_W-1:0]  cfg_idx,
	input  tok_type_t                 cfg_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	// ---------------- configuration registers ----------------
	pps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.marker  <= PPS_TYPE_W'(0);
			cfg_q.end_tok <= PPS_TYPE_W'(1);
			cfg_q.expr    <= PPS_TYPE_W'(2);
			cfg_q.ident   <= PPS_TYPE_W'(3);
		end else if (cfg_we) begin
			case (pps_reg_t'(cfg_idx))
				REG_MARKER: cfg_q.marker  <= cfg_data;
				REG_END:    cfg_q.end_tok <= cfg_data;
				REG_EXPR:   cfg_q.expr    <= cfg_data;
				REG_IDENT:  cfg_q.ident   <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- cell row ----------------
	tok_type_t               cell_type [DEPTH];
	logic [PAYLOAD_BITS-1:0] cell_pay  [DEPTH];
	cell_op_t                cell_op   [DEPTH];
	logic [DEPTH-1:0]        cell_ei;
	logic [DEPTH-1:0]        live;
	logic [DEPTH-1:0]        term;     // live and neither expression nor identifier
	logic [DEPTH-1:0]        run_flag;
	logic [DEPTH-1:0]        run;      // every live cell from here up is expr/ident
	logic [CW-1:0]           fill_q;
	logic [PAYLOAD_BITS-1:0] push_pay;

	// pushed payload kept to PAYLOAD_BITS
	generate
		if (PAYLOAD_BITS >= PPS_OUT_PAY_W) begin : g_pay_wide
			assign push_pay = PAYLOAD_BITS'(in_ch.token_payload);
		end else begin : g_pay_narrow
			assign push_pay = in_ch.token_payload[PAYLOAD_BITS-1:0];
		end
	endgenerate

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		if (j == 0) begin : g_bottom
			pps_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
				.clk        (clk),
				.op         (cell_op[j]),
				.cfg        (cfg_q),
				.push_type  (in_ch.token_type),
				.push_pay   (push_pay),
				.below_type ('0),
				.below_pay  ('0),
				.type_q     (cell_type[j]),
				.pay_q      (cell_pay[j]),
				.ei         (cell_ei[j])
			);
		end else begin : g_upper
			pps_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
				.clk        (clk),
				.op         (cell_op[j]),
				.cfg        (cfg_q),
				.push_type  (in_ch.token_type),
				.push_pay   (push_pay),
				.below_type (cell_type[j-1]),
				.below_pay  (cell_pay[j-1]),
				.type_q     (cell_type[j]),
				.pay_q      (cell_pay[j]),
				.ei         (cell_ei[j])
			);
		end
		assign live[j]     = CW'(j) < fill_q;
		assign term[j]     = live[j] & ~cell_ei[j];
		assign run_flag[j] = cell_ei[j] | ~live[j];
	end

	pps_scan #(.DEPTH(DEPTH)) u_scan (
		.flag (run_flag),
		.run  (run)
	);

	// ---------------- top of stack ----------------
	logic [CW-1:0]           top_pos;
	logic [IW-1:0]           top_idx;
	tok_type_t               top_type;
	logic [PAYLOAD_BITS-1:0] top_pay;
	logic                    empty;
	logic                    full;

	assign top_pos  = fill_q - CW'(1);
	assign top_idx  = top_pos[IW-1:0];
	assign top_type = cell_type[top_idx];
	assign top_pay  = cell_pay[top_idx];
	assign empty    = (fill_q == '0);
	assign full     = (fill_q == CW'(DEPTH));

	// ---------------- operation decode ----------------
	logic        acc;
	logic        pend_q;
	logic        push_go;
	logic        pop_go;
	logic        mark_top;   // marker straight onto the end token
	logic        mark_ins;   // marker above the first terminal
	pps_status_t st_d;
	pps_status_t status_q;
	logic [CW-1:0] fill_d;

	assign in_ch.ready = !pend_q;
	assign acc         = in_ch.valid && in_ch.ready;

	always_comb begin
		push_go  = 1'b0;
		pop_go   = 1'b0;
		mark_top = 1'b0;
		mark_ins = 1'b0;
		st_d     = ST_OK;
		case (pps_func_t'(in_ch.func))
			FN_PUSH: begin
				if (full) st_d = ST_FULL;
				else push_go = 1'b1;
			end
			FN_POP: begin
				if (empty) st_d = ST_EMPTY;
				else pop_go = 1'b1;
			end
			FN_TOP: begin
				if (empty) st_d = ST_EMPTY;
			end
			FN_INSERT: begin
				// end-token check takes priority over the terminal search
				if (empty) st_d = ST_NOTERM;
				else if (top_type == cfg_q.end_tok) begin
					if (full) st_d = ST_FULL;
					else mark_top = 1'b1;
				end else if (!(|term)) st_d = ST_NOTERM;
				else if (full) st_d = ST_FULL;
				else mark_ins = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (push_go || mark_top || mark_ins) fill_d = fill_q + CW'(1);
		else if (pop_go) fill_d = fill_q - CW'(1);
		else fill_d = fill_q;
	end

	// per-cell action: new entry at the fill position, or open a gap above the
	// first terminal and drop the marker into it
	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			cell_op[j] = CELL_HOLD;
			if (acc && CW'(j) == fill_q) begin
				if (push_go) cell_op[j] = CELL_PUSH;
				else if (mark_top) cell_op[j] = CELL_MARK;
			end
		end
		for (int j = 1; j < DEPTH; j++) begin
			if (acc && mark_ins) begin
				if (term[j-1] && run[j]) cell_op[j] = CELL_MARK;
				else if (run[j-1] && live[j-1]) cell_op[j] = CELL_SHIFT;
			end
		end
	end

	// ---------------- state and result register ----------------
	logic                       out_valid_q;
	logic                       out_load;
	logic                       res_top_valid_q;
	tok_type_t                  res_type_q;
	logic [PPS_OUT_PAY_W-1:0]   res_pay_q;
	logic [CW-1:0]              res_count_q;
	pps_status_t                res_status_q;
	logic [PPS_OUT_PAY_W-1:0]   top_pay_out;

	generate
		if (PAYLOAD_BITS >= PPS_OUT_PAY_W) begin : g_out_wide
			assign top_pay_out = top_pay[PPS_OUT_PAY_W-1:0];
		end else begin : g_out_narrow
			assign top_pay_out = PPS_OUT_PAY_W'(top_pay);
		end
	endgenerate

	assign out_load = pend_q && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (acc) begin
				fill_q   <= fill_d;
				status_q <= st_d;
				pend_q   <= 1'b1;
			end else if (out_load) begin
				pend_q <= 1'b0;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_top_valid_q <= !empty;
			res_type_q      <= empty ? '0 : top_type;
			res_pay_q       <= empty ? '0 : top_pay_out;
			res_count_q     <= fill_q;
			res_status_q    <= status_q;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.top_valid   = res_top_valid_q;
	assign out_ch.top_type    = res_type_q;
	assign out_ch.top_payload = res_pay_q;
	assign out_ch.entry_count = res_count_q;
	assign out_ch.status      = res_status_q;

endmodule
